### src/connection_keepalive_supervisor_assert.svh
// Assertion macros used by the checker module of this block.
`ifndef CONNECTION_KEEPALIVE_SUPERVISOR_ASSERT_SVH
`define CONNECTION_KEEPALIVE_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("connection_keepalive_supervisor: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CKS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("connection_keepalive_supervisor: assertion failed");

`endif

### src/cks_pkg.sv
package cks_pkg;

  localparam int unsigned CntWidth = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned InDataWidth = 8;
  localparam int unsigned OutDataWidth = 8;

  typedef logic [CntWidth-1:0] cnt_t;

  localparam cnt_t CntMax = '1;

  localparam cnt_t HeartbeatPeriodRst = 16'd6600;
  localparam cnt_t HeartbeatInitialRst = 16'd5600;
  localparam cnt_t RetryDelayRst = 16'd1000;
  localparam cnt_t ReplyTimeoutRst = 16'd15000;
  localparam cnt_t EstablishedTimeoutRst = 16'd2000;

  localparam logic [1:0] MissLimit = 2'd3;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegHeartbeatPeriod = 3'd0,
    RegHeartbeatInitial = 3'd1,
    RegRetryDelay = 3'd2,
    RegReplyTimeout = 3'd3,
    RegEstablishedTimeout = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhConn = 3'b010,
    PhDisc = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    LsIdle = 2'd0,
    LsConn = 2'd1,
    LsDisc = 2'd2
  } link_state_e;

  typedef struct packed {
    logic send_allowed;
    logic remote_closed;
    logic connected;
    logic connect_ok;
    logic ip_valid;
    logic dhcp_assigned;
    logic link_up;
  } in_fields_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic timed_out;
    logic address_refresh;
    logic send_heartbeat;
    logic disconnect_request;
    logic connect_request;
  } out_fields_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CntMax) ? CntMax : cnt_t'(v + 1'b1);
  endfunction

endpackage

### src/connection_keepalive_supervisor.sv
// Channel   | Direction | Payload
// s_axis    | in        | tuser: req_type; tdata: link_up .. send_allowed
// m_axis    | out       | tdata: requests, timed_out, link_state
// cfg       | in        | cfg_index_i register index, cfg_data_i 16-bit value
//
// Each beat is handled combinationally: the state update and the result are computed
// from the accepted input beat and stored in the state and output registers.
// One beat per cycle is sustained; the output register is the only buffering.
// The input side stalls only while a result waits and m_axis_tready_i is low.
// Reset loads the register defaults and puts the supervisor in idle.
module connection_keepalive_supervisor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // bit 0: req_type
  input  logic                                s_axis_tuser_i,
  // bits 0..6: link_up, dhcp_assigned, ip_valid, connect_ok, connected,
  // remote_closed, send_allowed; bit 7 zero
  input  logic [cks_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // bits 0..6: connect_request, disconnect_request, send_heartbeat,
  // address_refresh, timed_out, link_state[1:0]; bit 7 zero
  output logic [cks_pkg::OutDataWidth-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cks_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [cks_pkg::CntWidth-1:0]        cfg_data_i
);
  import cks_pkg::*;

  cnt_t hb_period_q, hb_initial_q, retry_delay_q, reply_timeout_q, est_timeout_q;

  phase_e phase_q, phase_d;
  cnt_t delay_q, delay_d;
  cnt_t hb_count_q, hb_count_d;
  logic hb_due_q, hb_due_d;
  cnt_t reply_q, reply_d;
  logic mark_q, mark_d;
  logic [1:0] miss_q, miss_d;

  logic [OutDataWidth-1:0] out_q;
  logic out_valid_q;

  in_fields_t in_f;
  out_fields_t res;
  logic accept;
  cnt_t reply_inc, delay_inc;
  logic [1:0] miss_inc;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_f = in_fields_t'(s_axis_tdata_i[6:0]);
  assign m_axis_tdata_o = out_q;
  assign m_axis_tvalid_o = out_valid_q;

  assign reply_inc = sat_inc(reply_q);
  assign delay_inc = sat_inc(delay_q);
  assign miss_inc = miss_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_period_q <= HeartbeatPeriodRst;
      hb_initial_q <= HeartbeatInitialRst;
      retry_delay_q <= RetryDelayRst;
      reply_timeout_q <= ReplyTimeoutRst;
      est_timeout_q <= EstablishedTimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegHeartbeatPeriod: hb_period_q <= cfg_data_i;
        RegHeartbeatInitial: hb_initial_q <= cfg_data_i;
        RegRetryDelay: retry_delay_q <= cfg_data_i;
        RegReplyTimeout: reply_timeout_q <= cfg_data_i;
        RegEstablishedTimeout: est_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    hb_count_d = hb_count_q;
    hb_due_d = hb_due_q;
    reply_d = reply_q;
    mark_d = mark_q;
    miss_d = miss_q;
    res = '0;
    if (s_axis_tuser_i) begin
      reply_d = '0;
    end else if (!in_f.link_up) begin
      reply_d = '0;
      hb_due_d = 1'b0;
      delay_d = '0;
      phase_d = PhIdle;
      hb_count_d = hb_initial_q;
      res.disconnect_request = 1'b1;
    end else begin
      if (hb_count_q >= hb_period_q) begin
        hb_count_d = '0;
        hb_due_d = 1'b1;
      end else begin
        hb_count_d = sat_inc(hb_count_q);
      end
      unique case (phase_q)
        PhIdle: begin
          if (delay_q >= retry_delay_q) begin
            delay_d = '0;
            if (in_f.dhcp_assigned && in_f.ip_valid) begin
              res.connect_request = 1'b1;
              if (in_f.connect_ok) begin
                reply_d = '0;
                phase_d = PhConn;
              end
            end
          end else begin
            delay_d = delay_inc;
          end
        end
        PhConn: begin
          reply_d = reply_inc;
          if (reply_inc >= reply_timeout_q) begin
            mark_d = 1'b1;
            res.address_refresh = 1'b1;
            phase_d = PhDisc;
          end else if (in_f.connected) begin
            delay_d = '0;
            mark_d = 1'b0;
            if (hb_due_d && in_f.send_allowed) begin
              hb_due_d = 1'b0;
              res.send_heartbeat = 1'b1;
            end
          end else if (in_f.remote_closed) begin
            phase_d = PhDisc;
          end else begin
            delay_d = delay_inc;
            if (delay_inc >= est_timeout_q) begin
              if (miss_inc >= MissLimit) begin
                miss_d = '0;
                mark_d = 1'b1;
                res.address_refresh = 1'b1;
              end else begin
                miss_d = miss_inc;
              end
              phase_d = PhDisc;
            end
          end
        end
        PhDisc: begin
          res.disconnect_request = 1'b1;
          reply_d = '0;
          hb_due_d = 1'b0;
          delay_d = '0;
          phase_d = PhIdle;
        end
        default: ;
      endcase
    end
    res.timed_out = mark_d;
    unique case (phase_d)
      PhConn: res.link_state = LsConn;
      PhDisc: res.link_state = LsDisc;
      default: res.link_state = LsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      delay_q <= '0;
      hb_count_q <= HeartbeatInitialRst;
      hb_due_q <= 1'b0;
      reply_q <= '0;
      mark_q <= 1'b0;
      miss_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        delay_q <= delay_d;
        hb_count_q <= hb_count_d;
        hb_due_q <= hb_due_d;
        reply_q <= reply_d;
        mark_q <= mark_d;
        miss_q <= miss_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= {1'b0, res};
    end
  end

endmodule

### src/cks_checker.sv
`include "connection_keepalive_supervisor_assert.svh"

module cks_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic [cks_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i
);
  import cks_pkg::*;

  out_fields_t res;
  assign res = out_fields_t'(m_axis_tdata_o[6:0]);

  `CKS_ASSERT_NEXT(stall_holds_beat, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `CKS_ASSERT_IMP(input_stall_only_on_full, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i)
  `CKS_ASSERT_IMP(disconnect_ends_idle, clk_i, rst_ni, m_axis_tvalid_o && res.disconnect_request, res.link_state == LsIdle && !res.connect_request)
  `CKS_ASSERT_IMP(refresh_drops_link, clk_i, rst_ni, m_axis_tvalid_o && res.address_refresh, res.timed_out && res.link_state == LsDisc)
  `CKS_ASSERT_IMP(heartbeat_when_connected, clk_i, rst_ni, m_axis_tvalid_o && res.send_heartbeat, res.link_state == LsConn && !res.timed_out)

endmodule

bind connection_keepalive_supervisor cks_checker u_cks_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cks_pkg::*;

  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumSegments = 8;
  localparam int unsigned SegmentBeats = 66;
  localparam int unsigned MaxReported = 10;
  localparam logic [CfgIdxWidth-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic       req_type;
    in_fields_t fields;
  } tick_beat_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_user = 1'b0;
  logic [InDataWidth-1:0]  s_data = '0;
  logic                    s_valid = 1'b0;
  logic                    s_ready;
  logic [OutDataWidth-1:0] m_data;
  logic                    m_valid;
  logic                    m_ready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  cnt_t                    cfg_data = '0;

  connection_keepalive_supervisor u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tuser_i  (s_user),
    .s_axis_tdata_i  (s_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Shadow copy of the supervisor: registers and state.
  cnt_t        hb_period = HeartbeatPeriodRst;
  cnt_t        hb_initial = HeartbeatInitialRst;
  cnt_t        retry_wait = RetryDelayRst;
  cnt_t        reply_limit = ReplyTimeoutRst;
  cnt_t        establish_limit = EstablishedTimeoutRst;
  link_state_e sup_phase = LsIdle;
  cnt_t        wait_cnt = '0;
  cnt_t        hb_cnt = HeartbeatInitialRst;
  logic        hb_due = 1'b0;
  cnt_t        reply_cnt = '0;
  logic        timeout_flag = 1'b0;
  logic [1:0]  miss_cnt = '0;

  tick_beat_t  pending_ticks[$];
  out_fields_t expected_reports[$];

  bit          in_taken = 1'b0;
  bit          link_est = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  int unsigned beats_in = 0;
  int unsigned reg_writes = 0;
  int unsigned n_connects = 0;
  int unsigned n_disconnects = 0;
  int unsigned n_heartbeats = 0;
  int unsigned n_refreshes = 0;

  function automatic cnt_t count_up(cnt_t v);
    return v + cnt_t'(v != CntMax);
  endfunction

  task automatic advance_supervisor(input tick_beat_t b, output out_fields_t r);
    r = '0;
    if (b.req_type) begin
      reply_cnt = '0;
    end else if (!b.fields.link_up) begin
      reply_cnt = '0;
      hb_due = 1'b0;
      wait_cnt = '0;
      sup_phase = LsIdle;
      hb_cnt = hb_initial;
      r.disconnect_request = 1'b1;
    end else begin
      if (hb_cnt >= hb_period) begin
        hb_cnt = '0;
        hb_due = 1'b1;
      end else begin
        hb_cnt = count_up(hb_cnt);
      end
      case (sup_phase)
        LsIdle: begin
          if (wait_cnt >= retry_wait) begin
            wait_cnt = '0;
            if (b.fields.dhcp_assigned && b.fields.ip_valid) begin
              r.connect_request = 1'b1;
              if (b.fields.connect_ok) begin
                reply_cnt = '0;
                sup_phase = LsConn;
              end
            end
          end else begin
            wait_cnt = count_up(wait_cnt);
          end
        end
        LsConn: begin
          reply_cnt = count_up(reply_cnt);
          if (reply_cnt >= reply_limit) begin
            timeout_flag = 1'b1;
            r.address_refresh = 1'b1;
            sup_phase = LsDisc;
          end else if (b.fields.connected) begin
            wait_cnt = '0;
            timeout_flag = 1'b0;
            if (hb_due && b.fields.send_allowed) begin
              hb_due = 1'b0;
              r.send_heartbeat = 1'b1;
            end
          end else if (b.fields.remote_closed) begin
            sup_phase = LsDisc;
          end else begin
            wait_cnt = count_up(wait_cnt);
            if (wait_cnt >= establish_limit) begin
              miss_cnt = miss_cnt + 2'd1;
              if (miss_cnt >= MissLimit) begin
                miss_cnt = '0;
                timeout_flag = 1'b1;
                r.address_refresh = 1'b1;
              end
              sup_phase = LsDisc;
            end
          end
        end
        LsDisc: begin
          r.disconnect_request = 1'b1;
          reply_cnt = '0;
          hb_due = 1'b0;
          wait_cnt = '0;
          sup_phase = LsIdle;
        end
        default: ;
      endcase
    end
    r.timed_out = timeout_flag;
    r.link_state = sup_phase;
  endtask

  always @(negedge clk_i) begin : drive_ticks
    tick_beat_t cur;
    if (!s_valid || in_taken) begin
      if (pending_ticks.size() != 0 && gap_left == 0) begin
        cur = pending_ticks.pop_front();
        s_user <= cur.req_type;
        s_data <= {1'b0, cur.fields};
        s_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(8, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin : watch_beats
    out_fields_t want;
    out_fields_t got;
    bit moved;
    in_taken = 1'b0;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        reg_writes++;
        case (cfg_index)
          RegHeartbeatPeriod:    hb_period = cfg_data;
          RegHeartbeatInitial:   hb_initial = cfg_data;
          RegRetryDelay:         retry_wait = cfg_data;
          RegReplyTimeout:       reply_limit = cfg_data;
          RegEstablishedTimeout: establish_limit = cfg_data;
          default: ;
        endcase
      end
      if (s_valid && s_ready) begin
        moved = 1'b1;
        in_taken = 1'b1;
        beats_in++;
        advance_supervisor('{req_type: s_user, fields: s_data[6:0]}, want);
        expected_reports.push_back(want);
        n_connects += want.connect_request;
        n_disconnects += want.disconnect_request;
        n_heartbeats += want.send_heartbeat;
        n_refreshes += want.address_refresh;
      end
      if (m_valid && m_ready) begin
        moved = 1'b1;
        got = m_data[6:0];
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= MaxReported)
            $display("unexpected result beat %b at %0t", got, $realtime);
        end else begin
          want = expected_reports.pop_front();
          if (got.connect_request !== want.connect_request ||
              got.disconnect_request !== want.disconnect_request ||
              got.send_heartbeat !== want.send_heartbeat ||
              got.address_refresh !== want.address_refresh ||
              got.timed_out !== want.timed_out ||
              got.link_state !== want.link_state) begin
            errors++;
            if (errors <= MaxReported) begin
              $display("mismatch at %0t: expected conn=%b disc=%b hb=%b refresh=%b timeout=%b state=%0d",
                       $realtime,
                       want.connect_request, want.disconnect_request, want.send_heartbeat,
                       want.address_refresh, want.timed_out, want.link_state);
              $display("  got conn=%b disc=%b hb=%b refresh=%b timeout=%b state=%0d",
                       got.connect_request, got.disconnect_request, got.send_heartbeat,
                       got.address_refresh, got.timed_out, got.link_state);
            end
          end
        end
      end
      if (moved) begin
        idle_cycles = 0;
      end else if (++idle_cycles >= StallLimit) begin
        $display("no beat moved for %0d cycles, %0d results outstanding", StallLimit,
                 expected_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input cnt_t val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || s_valid || expected_reports.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic push_tick(input logic req, input logic link, input logic dhcp,
                           input logic ip, input logic cok, input logic est,
                           input logic closed, input logic allowed);
    tick_beat_t b;
    b.req_type = req;
    b.fields = '{send_allowed: allowed, remote_closed: closed, connected: est,
                 connect_ok: cok, ip_valid: ip, dhcp_assigned: dhcp, link_up: link};
    pending_ticks.push_back(b);
  endtask

  task automatic push_random_tick();
    tick_beat_t b;
    if ($urandom_range(0, 6) == 0) begin
      b.req_type = 1'($urandom_range(0, 1));
      b.fields = in_fields_t'($urandom_range(0, 127));
    end else begin
      if ($urandom_range(0, 5) == 0) link_est = ~link_est;
      b.req_type = ($urandom_range(0, 11) == 0);
      b.fields.link_up = ($urandom_range(0, 39) != 0);
      b.fields.dhcp_assigned = ($urandom_range(0, 9) != 0);
      b.fields.ip_valid = ($urandom_range(0, 9) != 0);
      b.fields.connect_ok = ($urandom_range(0, 5) != 0);
      b.fields.connected = link_est;
      b.fields.remote_closed = ($urandom_range(0, 14) == 0);
      b.fields.send_allowed = 1'($urandom_range(0, 1));
    end
    pending_ticks.push_back(b);
  endtask

  task automatic configure_segment(input int unsigned seg);
    cnt_t period, initial_val, retry, reply, establish;
    if (seg == 0) begin
      period = '0; initial_val = '0; retry = '0; reply = '0; establish = '0;
    end else if (seg == NumSegments - 1) begin
      period = CntMax; initial_val = CntMax; retry = CntMax;
      reply = CntMax; establish = CntMax;
    end else begin
      period = cnt_t'($urandom_range(0, 8));
      initial_val = ($urandom_range(0, 3) == 0) ? cnt_t'($urandom_range(0, CntMax))
                                                 : cnt_t'($urandom_range(0, 8));
      retry = cnt_t'($urandom_range(0, 4));
      reply = (seg == 3) ? CntMax : cnt_t'($urandom_range(2, 24));
      establish = cnt_t'($urandom_range(1, 6));
    end
    write_reg(RegHeartbeatPeriod, period);
    write_reg(RegHeartbeatInitial, initial_val);
    write_reg(RegRetryDelay, retry);
    write_reg(RegReplyTimeout, reply);
    write_reg(RegEstablishedTimeout, establish);
    write_reg(CfgIdxWidth'($urandom_range(RegSpareLo, RegSpareHi)),
              cnt_t'($urandom_range(0, CntMax)));
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Received messages ignore the link inputs; a link-down tick tears down.
    push_tick(1, 1, 1, 1, 1, 1, 1, 1);
    push_tick(1, 0, 0, 0, 0, 0, 0, 0);
    push_tick(0, 1, 1, 1, 1, 1, 1, 1);
    push_tick(0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    write_reg(RegHeartbeatPeriod, 16'd1);
    write_reg(RegHeartbeatInitial, 16'd0);
    write_reg(RegRetryDelay, 16'd1);
    write_reg(RegReplyTimeout, 16'd4);
    write_reg(RegEstablishedTimeout, 16'd2);
    write_reg(RegSpareLo, CntMax);

    // Invalid destination, refused connect, then a real connect.
    push_tick(0, 1, 0, 1, 1, 0, 0, 0);
    push_tick(0, 1, 1, 0, 1, 0, 0, 0);
    push_tick(0, 1, 1, 1, 0, 0, 0, 0);
    push_tick(0, 1, 1, 1, 0, 0, 0, 0);
    push_tick(0, 1, 1, 1, 1, 0, 0, 0);
    push_tick(0, 1, 1, 1, 1, 0, 0, 0);
    // Established with heartbeats, a reply, then a remote close.
    push_tick(0, 1, 1, 1, 1, 1, 0, 1);
    push_tick(1, 1, 1, 1, 1, 1, 0, 1);
    push_tick(0, 1, 1, 1, 1, 1, 0, 0);
    push_tick(0, 1, 1, 1, 1, 0, 1, 1);
    push_tick(0, 1, 1, 1, 1, 0, 0, 0);
    push_tick(0, 0, 1, 1, 1, 1, 1, 1);
    // Reconnect and let the reply timer expire.
    push_tick(0, 1, 1, 1, 1, 0, 0, 0);
    push_tick(0, 1, 1, 1, 1, 0, 0, 0);
    for (int i = 0; i < 4; i++) push_tick(0, 1, 1, 1, 1, 1, 0, 1);
    push_tick(0, 1, 1, 1, 1, 1, 0, 1);

    for (int unsigned seg = 0; seg < NumSegments; seg++) begin
      drain();
      configure_segment(seg);
      link_est = $urandom_range(0, 1);
      repeat (SegmentBeats) push_random_tick();
    end
    drain();

    $display("Ran %0d input beats over %0d register writes and %0d settings.",
             beats_in, reg_writes, NumSegments + 2);
    $display("Seen: %0d connects, %0d disconnects, %0d heartbeats, %0d refreshes.",
             n_connects, n_disconnects, n_heartbeats, n_refreshes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
